// ===== design/tlsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Texture level size package
// Payload types, format table and sizing constants for the level size unit.
// ----------------------------------------------------------------------------
package tlsc_pkg;

   localparam int MAX_LOG2_DIM = 14;
   localparam int NUM_FORMATS  = 25;
   localparam int BLOCK_LOG2   = 2;

   localparam int CODE_W  = 5;
   localparam int DIM_W   = 15;
   localparam int DEPTH_W = 12;
   localparam int LEVEL_W = 5;
   localparam int ROW_W   = 19;
   localparam int LAYER_W = 44;
   localparam int CHAIN_W = 4;
   localparam int BPB_W   = 5;

   typedef struct packed {
      logic [CODE_W-1:0]  format_code;
      logic [DIM_W-1:0]   base_width;
      logic [DIM_W-1:0]   base_height;
      logic [DEPTH_W-1:0] base_depth;
      logic [LEVEL_W-1:0] level_index;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]   row_bytes;
      logic [LAYER_W-1:0] layer_bytes;
      logic [CHAIN_W-1:0] chain_levels;
      logic               depth_stencil_flag;
      logic               compressed_flag;
      logic               unsupported_flag;
   } rsp_type;

   typedef struct packed {
      logic [BPB_W-1:0] bpb;
      logic             cmp;
      logic             ds;
   } fmt_type;

   function automatic fmt_type fmt_lookup(input logic [CODE_W-1:0] code);
      fmt_type f;
      f = '{bpb: BPB_W'(1), cmp: 1'b0, ds: 1'b0};
      case (code)
         5'd1:  f.bpb = BPB_W'(1);
         5'd2, 5'd3, 5'd4, 5'd6: f.bpb = BPB_W'(2);
         5'd5, 5'd7, 5'd8, 5'd9, 5'd11, 5'd15, 5'd16, 5'd17: f.bpb = BPB_W'(4);
         5'd10, 5'd13: f.bpb = BPB_W'(8);
         5'd12, 5'd14: f.bpb = BPB_W'(16);
         5'd18, 5'd19: f = '{bpb: BPB_W'(8), cmp: 1'b1, ds: 1'b0};
         5'd20: f = '{bpb: BPB_W'(16), cmp: 1'b1, ds: 1'b0};
         5'd21: f = '{bpb: BPB_W'(2), cmp: 1'b0, ds: 1'b1};
         5'd22: f = '{bpb: BPB_W'(3), cmp: 1'b0, ds: 1'b1};
         5'd23, 5'd24: f = '{bpb: BPB_W'(4), cmp: 1'b0, ds: 1'b1};
         default: f = '{bpb: BPB_W'(1), cmp: 1'b0, ds: 1'b0};
      endcase
      return f;
   endfunction

endpackage

// ===== design/texture_level_size_calc_unit.sv =====
// ----------------------------------------------------------------------------
// Texture level size calculation unit
// Row and layer byte counts of one mip level, with chain length and format
// flags, computed in a four-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   A query is transferred at a rising edge with start high and busy low.
//   busy is held low: a new query may be transferred in every cycle.
//   The result appears on rsp_item with strobe high for exactly one cycle;
//   the receiver cannot stall, so nothing is held back and results leave
//   in query order.
//   Throughput is one query per cycle; latency is set by the chain of
//   stages: table lookup and level shift, width by height multiply,
//   multiply by depth, multiply by bytes per block.
//   Synchronous reset drops every query in flight; no strobe follows it
//   until new queries are transferred.
// ----------------------------------------------------------------------------
module texture_level_size_calc_unit
   import tlsc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    strobe,
   output rsp_type rsp_item
);

   localparam int BLK_W  = DIM_W - BLOCK_LOG2 + 1;
   localparam int AREA_W = 2 * DIM_W;
   localparam int VOL_W  = AREA_W + DEPTH_W;
   localparam int PROD_W = VOL_W + BPB_W;
   localparam int LVL_W  = 5;

   // stage 1
   logic                v1_ff;
   fmt_type             fmt1_ff;
   logic [DIM_W-1:0]    w1_ff, w1_in;
   logic [DIM_W-1:0]    h1_ff, h1_in;
   logic [DEPTH_W-1:0]  d1_ff, d1_in;
   logic                unsup1_ff;
   logic [CHAIN_W-1:0]  chain1_ff, chain1_in;
   fmt_type             fmt1_in;
   logic [DIM_W-1:0]    dims_or;
   logic [LVL_W-1:0]    levels_raw;

   // stage 2
   logic                v2_ff;
   fmt_type             fmt2_ff;
   logic [AREA_W-1:0]   area2_ff;
   logic [DEPTH_W-1:0]  d2_ff;
   logic                unsup2_ff;
   logic [CHAIN_W-1:0]  chain2_ff;
   logic [ROW_W-1:0]    row2_ff, row2_in;
   logic [DIM_W-1:0]    ma, mb;
   logic [BLK_W-1:0]    wb, hb;

   // stage 3
   logic                v3_ff;
   fmt_type             fmt3_ff;
   logic [VOL_W-1:0]    vol3_ff;
   logic                unsup3_ff;
   logic [CHAIN_W-1:0]  chain3_ff;
   logic [ROW_W-1:0]    row3_ff;

   // stage 4
   logic                v4_ff;
   rsp_type             rsp4_ff, rsp4_in;
   logic [PROD_W-1:0]   prod;

   always_comb begin
      fmt1_in = fmt_lookup(req_item.format_code);
      w1_in   = req_item.base_width >> req_item.level_index;
      h1_in   = req_item.base_height >> req_item.level_index;
      d1_in   = req_item.base_depth >> req_item.level_index;
      if (w1_in == '0) w1_in = DIM_W'(1);
      if (h1_in == '0) h1_in = DIM_W'(1);
      if (d1_in == '0) d1_in = DEPTH_W'(1);
      dims_or    = req_item.base_width | req_item.base_height;
      levels_raw = LVL_W'(1);
      for (int i = 1; i < DIM_W; i++) begin
         if (dims_or[i]) levels_raw = LVL_W'(i + 1);
      end
      if (levels_raw > LVL_W'(MAX_LOG2_DIM + 1)) levels_raw = LVL_W'(MAX_LOG2_DIM + 1);
      chain1_in = levels_raw[CHAIN_W-1:0];
   end

   always_comb begin
      wb = BLK_W'((DIM_W+1)'(w1_ff) + (DIM_W+1)'(3) >> BLOCK_LOG2);
      hb = BLK_W'((DIM_W+1)'(h1_ff) + (DIM_W+1)'(3) >> BLOCK_LOG2);
      ma = fmt1_ff.cmp ? DIM_W'(wb) : w1_ff;
      mb = fmt1_ff.cmp ? DIM_W'(hb) : h1_ff;
      row2_in = ROW_W'(ma) * ROW_W'(fmt1_ff.bpb);
   end

   always_comb begin
      prod = PROD_W'(vol3_ff) * PROD_W'(fmt3_ff.bpb);
      rsp4_in.row_bytes          = row3_ff;
      rsp4_in.layer_bytes        = unsup3_ff ? '0 : prod[LAYER_W-1:0];
      rsp4_in.chain_levels       = chain3_ff;
      rsp4_in.depth_stencil_flag = fmt3_ff.ds;
      rsp4_in.compressed_flag    = fmt3_ff.cmp;
      rsp4_in.unsupported_flag   = unsup3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      fmt1_ff   <= fmt1_in;
      w1_ff     <= w1_in;
      h1_ff     <= h1_in;
      d1_ff     <= d1_in;
      unsup1_ff <= fmt1_in.cmp && (req_item.base_depth > DEPTH_W'(1));
      chain1_ff <= chain1_in;

      fmt2_ff   <= fmt1_ff;
      area2_ff  <= AREA_W'(ma) * AREA_W'(mb);
      d2_ff     <= d1_ff;
      unsup2_ff <= unsup1_ff;
      chain2_ff <= chain1_ff;
      row2_ff   <= row2_in;

      fmt3_ff   <= fmt2_ff;
      vol3_ff   <= VOL_W'(area2_ff) * VOL_W'(d2_ff);
      unsup3_ff <= unsup2_ff;
      chain3_ff <= chain2_ff;
      row3_ff   <= row2_ff;

      rsp4_ff   <= rsp4_in;
   end

   assign busy     = 1'b0;
   assign strobe   = v4_ff;
   assign rsp_item = rsp4_ff;

   assert property (@(posedge clock) disable iff (reset) start |-> ##4 strobe)
      else $error("transfer lost in pipeline");

   assert property (@(posedge clock) disable iff (reset) strobe |-> $past(start, 4))
      else $error("result without a transferred query");

   assert property (@(posedge clock) disable iff (reset)
      strobe && rsp_item.unsupported_flag |->
         rsp_item.compressed_flag && (rsp_item.layer_bytes == '0))
      else $error("unsupported result carries a layer size");

endmodule
